// ----- rtl/car_pkg.sv -----
// Shared types and constants for the comb and allpass reverberator.
`timescale 1ns / 1ps
package car_pkg;

    localparam int NCOMB = 8;
    localparam int NAP = 4;
    localparam int VW = 24;

    localparam logic signed [VW-1:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [VW-1:0] SAT_MIN = -24'sh800000;

    localparam logic [16:0] GAIN_IN = 17'd19661;
    localparam logic [16:0] GAIN_AP = 17'd32768;
    localparam logic [16:0] GAIN_ONE = 17'd65536;

    // Register indexes.
    localparam logic [1:0] REG_FEEDBACK = 2'd0;
    localparam logic [1:0] REG_DAMPING = 2'd1;
    localparam logic [1:0] REG_WET = 2'd2;
    localparam logic [1:0] REG_DRY = 2'd3;

    // Sequencer states.
    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b0000000001,
        ST_IDLE    = 10'b0000000010,
        ST_SCALE   = 10'b0000000100,
        ST_CREAD   = 10'b0000001000,
        ST_CFILT   = 10'b0000010000,
        ST_CWRITE  = 10'b0000100000,
        ST_AREAD   = 10'b0001000000,
        ST_AWRITE  = 10'b0010000000,
        ST_MIX     = 10'b0100000000,
        ST_OUT     = 10'b1000000000
    } state_t;

    // Operands of the shared multiply-add unit.
    typedef struct packed {
        logic signed [VW-1:0] a0;
        logic [16:0]          g0;
        logic signed [VW-1:0] a1;
        logic [16:0]          g1;
        logic signed [VW-1:0] add;
    } mac_op_t;

    // Saturate a wide value to the internal 24-bit range.
    function automatic logic signed [VW-1:0] sat24(input logic signed [47:0] v);
        logic signed [VW-1:0] r;
        if (v > 48'(SAT_MAX)) r = SAT_MAX;
        else if (v < 48'(SAT_MIN)) r = SAT_MIN;
        else r = v[VW-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/car_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module car_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/car_mac.sv -----
// Shared multiply-add unit: rounded sum of two gain products plus an addend.
`timescale 1ns / 1ps
module car_mac (
    input  logic                            aclk,
    input  car_pkg::mac_op_t                op,
    output logic signed [car_pkg::VW-1:0]   result
);
    import car_pkg::*;

    logic signed [41:0] p0_reg, p1_reg;
    logic signed [VW-1:0] add_reg;
    logic signed [44:0] sum;
    logic signed [28:0] rnd;

    // First stage: two 24x17 products, registered.
    always_ff @(posedge aclk) begin
        p0_reg  <= op.a0 * $signed({1'b0, op.g0});
        p1_reg  <= op.a1 * $signed({1'b0, op.g1});
        add_reg <= op.add;
    end

    // Second stage: round half up, add, saturate.
    always_comb begin
        sum = 45'(p0_reg) + 45'(p1_reg) + 45'sd32768;
        rnd = sum[44:16];
    end

    always_ff @(posedge aclk) begin
        result <= sat24(48'(rnd) + 48'(add_reg));
    end
endmodule

// ----- rtl/comb_allpass_reverb.sv -----
// Top level of the eight-comb, four-allpass reverberator.
//
// Input items arrive on the s_ channel: tdata carries sample_in, tuser the
// block_end mark. Each item gives one result on the m_ channel, sample_out in
// tdata and the copied mark in tuser. The user writes gains on cfg_ (index 0
// feedback, 1 damping, 2 wet, 3 dry) only while idle, not enforced by the block.
//
// One sequencer drives one shared two-stage multiply-add unit. An item takes
// a scaling step, a read, filter and write step per comb, a read and write
// step per allpass, a mix step and an output step, each unit step waiting out
// the unit's latency. The next item is accepted only after the output step;
// s_tready is low during that work.
// After reset the delay memories are cleared one address a cycle, up to the
// larger of COMB_DEPTH and ALLPASS_DEPTH, with s_tready low.
// The comb lines share one memory and the allpass lines another, their lanes side by side in one word.
// The result waits in an output register while m_tready is low; the next
// item is still taken and worked on, and the sequencer holds in its output
// step until the waiting result has been taken.
`timescale 1ns / 1ps
module comb_allpass_reverb #(
    parameter int SAMPLE_RATE = 16000,
    parameter int COMB_DEPTH = 1024,
    parameter int ALLPASS_DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    input  logic        s_tuser,   // [0] block_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    output logic        m_tuser,   // [0] block_end_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import car_pkg::*;

    localparam int CAW = $clog2(COMB_DEPTH);
    localparam int AAW = $clog2(ALLPASS_DEPTH);
    localparam int CLW = (CAW > AAW) ? CAW : AAW;

    function automatic int dlen(input int tune, input int depth);
        int n;
        n = (tune * SAMPLE_RATE) / 44100;
        if (n > depth - 1) n = depth - 1;
        if (n < 1) n = 1;
        return n;
    endfunction

    localparam int CT [NCOMB] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    localparam int AT [NAP] = '{556, 441, 341, 225};

    logic [CAW-1:0] clen [NCOMB];
    logic [AAW-1:0] alen [NAP];
    for (genvar g = 0; g < NCOMB; g++) begin : g_clen
        assign clen[g] = CAW'(dlen(CT[g], COMB_DEPTH));
    end
    for (genvar g = 0; g < NAP; g++) begin : g_alen
        assign alen[g] = AAW'(dlen(AT[g], ALLPASS_DEPTH));
    end

    state_t state_reg, state_next;
    logic [15:0] fb_reg, damp_reg, wet_reg, dry_reg;
    logic [CLW:0] clr_reg;
    logic [2:0] lane_reg;
    logic [1:0] wait_reg;
    logic signed [15:0] s_reg;
    logic tuser_reg;
    logic signed [VW-1:0] x_reg, acc_reg, y_reg;
    logic signed [27:0] sum_reg;
    logic signed [VW-1:0] filt_reg [NCOMB];
    logic [CAW-1:0] cpos_reg [NCOMB];
    logic [AAW-1:0] apos_reg [NAP];
    logic m_valid_reg;
    logic [15:0] m_data_reg;
    logic m_user_reg;
    logic [15:0] res_data_reg;
    logic res_user_reg;
    logic out_free;

    mac_op_t op;
    logic signed [VW-1:0] mac_res;

    car_mac u_mac (.aclk(aclk), .op(op), .result(mac_res));

    // Comb memory: eight lanes per word, one word per delay position.
    logic c_we, a_we;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [AAW-1:0] a_waddr, a_raddr;
    logic [NCOMB*VW-1:0] c_wdata, c_rdata, c_word_reg;
    logic [NAP*VW-1:0] a_wdata, a_rdata, a_word_reg;

    car_ram #(.WIDTH(NCOMB*VW), .DEPTH(COMB_DEPTH)) u_comb_ram (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata));
    car_ram #(.WIDTH(NAP*VW), .DEPTH(ALLPASS_DEPTH)) u_ap_ram (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata));

    // Lanes share one word, so each lane keeps its own address; a lane word
    // is read-modify-written per lane from a captured copy.
    logic [CAW-1:0] cpos_cur;
    logic [AAW-1:0] apos_cur;
    logic signed [VW-1:0] c_lane, a_lane;
    assign cpos_cur = cpos_reg[lane_reg];
    assign apos_cur = apos_reg[lane_reg[1:0]];
    assign c_lane = c_rdata[lane_reg*VW +: VW];
    assign a_lane = a_rdata[lane_reg[1:0]*VW +: VW];

    // The output register can take a new result when empty or being taken.
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

    // Operand selection for the shared unit.
    always_comb begin
        op = '0;
        case (state_reg)
            ST_SCALE: begin
                op.a0 = VW'(s_reg);
                op.g0 = GAIN_IN;
            end
            ST_CFILT: begin
                op.a0 = y_reg;
                op.g0 = GAIN_ONE - {1'b0, damp_reg};
                op.a1 = filt_reg[lane_reg];
                op.g1 = {1'b0, damp_reg};
            end
            ST_CWRITE: begin
                op.a0 = filt_reg[lane_reg];
                op.g0 = {1'b0, fb_reg};
                op.add = x_reg;
            end
            ST_AWRITE: begin
                op.a0 = y_reg;
                op.g0 = GAIN_AP;
                op.add = acc_reg;
            end
            ST_MIX: begin
                op.a0 = VW'(s_reg);
                op.g0 = {1'b0, dry_reg};
                op.a1 = acc_reg;
                op.g1 = {1'b0, wet_reg};
            end
            default: op = '0;
        endcase
    end

    // Memory ports.
    always_comb begin
        c_we = 1'b0;
        a_we = 1'b0;
        c_waddr = cpos_cur;
        a_waddr = apos_cur;
        c_raddr = cpos_cur;
        a_raddr = apos_cur;
        c_wdata = c_word_reg;
        a_wdata = a_word_reg;
        if (state_reg == ST_CLEAR) begin
            c_we = (clr_reg < (CLW+1)'(COMB_DEPTH));
            a_we = (clr_reg < (CLW+1)'(ALLPASS_DEPTH));
            c_waddr = clr_reg[CAW-1:0];
            a_waddr = clr_reg[AAW-1:0];
            c_wdata = '0;
            a_wdata = '0;
        end else if (state_reg == ST_CWRITE && wait_reg == 2'd2) begin
            c_we = 1'b1;
            c_wdata[lane_reg*VW +: VW] = mac_res;
        end else if (state_reg == ST_AWRITE && wait_reg == 2'd2) begin
            a_we = 1'b1;
            a_wdata[lane_reg[1:0]*VW +: VW] = mac_res;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == (CLW+1)'(COMB_DEPTH > ALLPASS_DEPTH ?
                                         COMB_DEPTH : ALLPASS_DEPTH) - 1'b1)
                           state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid && s_tready) state_next = ST_SCALE;
            ST_SCALE:  if (wait_reg == 2'd2) state_next = ST_CREAD;
            ST_CREAD:  if (wait_reg == 2'd1) state_next = ST_CFILT;
            ST_CFILT:  if (wait_reg == 2'd2) state_next = ST_CWRITE;
            ST_CWRITE: if (wait_reg == 2'd2)
                           state_next = (lane_reg == 3'(NCOMB-1)) ? ST_AREAD : ST_CREAD;
            ST_AREAD:  if (wait_reg == 2'd1) state_next = ST_AWRITE;
            ST_AWRITE: if (wait_reg == 2'd2)
                           state_next = (lane_reg == 3'(NAP-1)) ? ST_MIX : ST_AREAD;
            ST_MIX:    if (wait_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            fb_reg <= 16'd47186;
            damp_reg <= 16'd29491;
            wet_reg <= 16'd22938;
            dry_reg <= 16'd52429;
            clr_reg <= '0;
            lane_reg <= '0;
            wait_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NCOMB; i++) begin
                filt_reg[i] <= '0;
                cpos_reg[i] <= '0;
            end
            for (int i = 0; i < NAP; i++) apos_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) wait_reg <= '0;
            else wait_reg <= wait_reg + 2'd1;

            if (cfg_valid) begin
                case (cfg_index)
                    REG_FEEDBACK: fb_reg <= cfg_data;
                    REG_DAMPING:  damp_reg <= cfg_data;
                    REG_WET:      wet_reg <= cfg_data;
                    REG_DRY:      dry_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Output register: loaded from the output step, emptied when taken.
            if (state_reg == ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        s_reg <= s_tdata;
                        tuser_reg <= s_tuser;
                        lane_reg <= '0;
                        sum_reg <= '0;
                    end
                end
                ST_SCALE: if (wait_reg == 2'd2) x_reg <= mac_res;
                ST_CREAD: if (wait_reg == 2'd1) begin
                    y_reg <= c_lane;
                    c_word_reg <= c_rdata;
                    sum_reg <= sum_reg + 28'(c_lane);
                end
                ST_CFILT: if (wait_reg == 2'd2) filt_reg[lane_reg] <= mac_res;
                ST_CWRITE: if (wait_reg == 2'd2) begin
                    cpos_reg[lane_reg] <= (cpos_cur + 1'b1 >= clen[lane_reg]) ?
                                          '0 : cpos_cur + 1'b1;
                    if (lane_reg == 3'(NCOMB-1)) begin
                        lane_reg <= '0;
                        acc_reg <= sat24(48'(sum_reg));
                    end else begin
                        lane_reg <= lane_reg + 3'd1;
                    end
                end
                ST_AREAD: if (wait_reg == 2'd1) begin
                    y_reg <= a_lane;
                    a_word_reg <= a_rdata;
                end
                ST_AWRITE: if (wait_reg == 2'd2) begin
                    apos_reg[lane_reg[1:0]] <= (apos_cur + 1'b1 >= alen[lane_reg[1:0]]) ?
                                               '0 : apos_cur + 1'b1;
                    acc_reg <= sat24(48'(y_reg) - 48'(acc_reg));
                    lane_reg <= lane_reg + 3'd1;
                end
                ST_MIX: if (wait_reg == 2'd2) begin
                    if (mac_res > 24'sd32767) res_data_reg <= 16'h7FFF;
                    else if (mac_res < -24'sd32768) res_data_reg <= 16'h8000;
                    else res_data_reg <= mac_res[15:0];
                    res_user_reg <= tuser_reg;
                end
                ST_OUT: if (out_free) begin
                    m_data_reg <= res_data_reg;
                    m_user_reg <= res_user_reg;
                end
                default: ;
            endcase
        end
    end

    // A stalled result holds its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");
    // A result appears only at the end of the sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside of the output step");
    // The lane 0 positions stay inside their delay lengths.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cpos_reg[0] < clen[0] && apos_reg[0] < alen[0])
        else $error("delay position out of range");
endmodule
